/* src/dnsa_pkg.sv */
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared types and constants for the DNS reply A-record scanner.
// ----------------------------------------------------------------------------
package dnsa_pkg;

    // Message and name limits
    localparam int MAX_MESSAGE_BYTES   = 512;
    localparam int MAX_LABELS_PER_NAME = 128;

    // Byte counter holds up to MAX_MESSAGE_BYTES + 1 (saturation point)
    localparam int OFFSET_W = $clog2(MAX_MESSAGE_BYTES + 2);

    // Fixed header length
    localparam int HEADER_BYTES = 12;

    // Header flag bit positions
    localparam int QR_BIT = 15;
    localparam int TC_BIT = 9;

    // Result status codes
    localparam logic [3:0] ST_FOUND        = 4'd0;
    localparam logic [3:0] ST_SHORT        = 4'd1;
    localparam logic [3:0] ST_LONG         = 4'd2;
    localparam logic [3:0] ST_NOT_RESPONSE = 4'd3;
    localparam logic [3:0] ST_TRUNCATED    = 4'd4;
    localparam logic [3:0] ST_RCODE        = 4'd5;
    localparam logic [3:0] ST_NO_ANSWERS   = 4'd6;
    localparam logic [3:0] ST_MALFORMED    = 4'd7;
    localparam logic [3:0] ST_NO_A         = 4'd8;

    // Record type / class / length of an IN A record
    localparam logic [15:0] TYPE_A    = 16'd1;
    localparam logic [15:0] CLASS_IN  = 16'd1;
    localparam logic [15:0] A_RDLEN   = 16'd4;

    // Input word: one message byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } byte_word_t;

    // Output word: one scan result
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] ipv4_address;
    } result_word_t;

endpackage

/* src/dnsa_parse.sv */
// ----------------------------------------------------------------------------
// dnsa_parse
// Per-byte scan state: header checks, name skipping, record walk and
// address capture. One byte is consumed per step; the final byte of a
// message produces the result and returns the state to its reset values.
// ----------------------------------------------------------------------------
module dnsa_parse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  dnsa_pkg::byte_word_t       word,
    output logic                       res_load,
    output dnsa_pkg::result_word_t     res_word
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QPTR,
        PH_QLABEL,
        PH_QFIXED,
        PH_ANAME,
        PH_APTR,
        PH_ALABEL,
        PH_AFIXED,
        PH_RDATA,
        PH_CAPTURE,
        PH_FOUND,
        PH_NO_A,
        PH_ERROR
    } phase_t;

    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFF_MAX =
        dnsa_pkg::OFFSET_W'(dnsa_pkg::MAX_MESSAGE_BYTES);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFF_HDR_LAST =
        dnsa_pkg::OFFSET_W'(dnsa_pkg::HEADER_BYTES - 1);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFF_HDR =
        dnsa_pkg::OFFSET_W'(dnsa_pkg::HEADER_BYTES);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFF_ONE = dnsa_pkg::OFFSET_W'(1);
    localparam logic [7:0] LABELS_MAX = 8'(dnsa_pkg::MAX_LABELS_PER_NAME);

    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_2 = dnsa_pkg::OFFSET_W'(2);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_3 = dnsa_pkg::OFFSET_W'(3);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_4 = dnsa_pkg::OFFSET_W'(4);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_5 = dnsa_pkg::OFFSET_W'(5);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_6 = dnsa_pkg::OFFSET_W'(6);
    localparam logic [dnsa_pkg::OFFSET_W-1:0] OFFSET_7 = dnsa_pkg::OFFSET_W'(7);

    phase_t                        phase_reg,  phase_next;
    logic [dnsa_pkg::OFFSET_W-1:0] off_reg,    off_next;
    logic [15:0]                   flags_reg,  flags_next;
    logic [15:0]                   qleft_reg,  qleft_next;
    logic [15:0]                   aleft_reg,  aleft_next;
    logic [5:0]                    lbl_reg,    lbl_next;
    logic [7:0]                    labels_reg, labels_next;
    logic [3:0]                    ffi_reg,    ffi_next;
    logic [15:0]                   rtype_reg,  rtype_next;
    logic [15:0]                   rclass_reg, rclass_next;
    logic [15:0]                   rdlen_reg,  rdlen_next;
    logic [31:0]                   addr_reg,   addr_next;
    logic [3:0]                    sticky_reg, sticky_next;

    // Compute next scan state and the result for a final byte
    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  ffi_inc;
        logic [15:0] cnt_dec;
        logic [5:0]  lbl_dec;

        b        = word.data_byte;
        ffi_inc  = ffi_reg + 4'd1;
        cnt_dec  = 16'd0;
        lbl_dec  = lbl_reg - 6'd1;

        phase_next  = phase_reg;
        off_next    = off_reg;
        flags_next  = flags_reg;
        qleft_next  = qleft_reg;
        aleft_next  = aleft_reg;
        lbl_next    = lbl_reg;
        labels_next = labels_reg;
        ffi_next    = ffi_reg;
        rtype_next  = rtype_reg;
        rclass_next = rclass_reg;
        rdlen_next  = rdlen_reg;
        addr_next   = addr_reg;
        sticky_next = sticky_reg;

        res_word.status       = dnsa_pkg::ST_MALFORMED;
        res_word.ipv4_address = 32'd0;

        // Parse only bytes inside the message limit
        if (off_reg < OFF_MAX)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (off_reg)
                        OFFSET_2:  flags_next = {b, 8'd0};
                        OFFSET_3:  flags_next = {flags_reg[15:8], b};
                        OFFSET_4:  qleft_next = {b, 8'd0};
                        OFFSET_5:  qleft_next = {qleft_reg[15:8], b};
                        OFFSET_6:  aleft_next = {b, 8'd0};
                        OFFSET_7:  aleft_next = {aleft_reg[15:8], b};
                        OFF_HDR_LAST:
                        begin
                            priority if (!flags_reg[dnsa_pkg::QR_BIT])
                            begin
                                sticky_next = dnsa_pkg::ST_NOT_RESPONSE;
                                phase_next  = PH_ERROR;
                            end
                            else if (flags_reg[dnsa_pkg::TC_BIT])
                            begin
                                sticky_next = dnsa_pkg::ST_TRUNCATED;
                                phase_next  = PH_ERROR;
                            end
                            else if (flags_reg[3:0] != 4'd0)
                            begin
                                sticky_next = dnsa_pkg::ST_RCODE;
                                phase_next  = PH_ERROR;
                            end
                            else if (aleft_reg == 16'd0)
                            begin
                                sticky_next = dnsa_pkg::ST_NO_ANSWERS;
                                phase_next  = PH_ERROR;
                            end
                            else
                            begin
                                labels_next = 8'd0;
                                phase_next  = (qleft_reg == 16'd0) ? PH_ANAME : PH_QNAME;
                            end
                        end
                        default: ;
                    endcase
                end

                PH_QNAME, PH_ANAME:
                begin
                    priority if (b[7:6] == 2'b11)
                    begin
                        phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                    end
                    else if (b == 8'd0)
                    begin
                        ffi_next   = 4'd0;
                        phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    end
                    else if (b[7:6] != 2'b00 || labels_reg >= LABELS_MAX)
                    begin
                        sticky_next = dnsa_pkg::ST_MALFORMED;
                        phase_next  = PH_ERROR;
                    end
                    else
                    begin
                        labels_next = labels_reg + 8'd1;
                        lbl_next    = b[5:0];
                        phase_next  = (phase_reg == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                    end
                end

                // Second pointer byte: consume and drop
                PH_QPTR, PH_APTR:
                begin
                    ffi_next   = 4'd0;
                    phase_next = (phase_reg == PH_QPTR) ? PH_QFIXED : PH_AFIXED;
                end

                PH_QLABEL, PH_ALABEL:
                begin
                    lbl_next = lbl_dec;
                    if (lbl_dec == 6'd0)
                    begin
                        phase_next = (phase_reg == PH_QLABEL) ? PH_QNAME : PH_ANAME;
                    end
                end

                PH_QFIXED:
                begin
                    ffi_next = ffi_inc;
                    if (ffi_inc >= 4'd4)
                    begin
                        cnt_dec     = qleft_reg - 16'd1;
                        qleft_next  = cnt_dec;
                        labels_next = 8'd0;
                        phase_next  = (cnt_dec == 16'd0) ? PH_ANAME : PH_QNAME;
                    end
                end

                PH_AFIXED:
                begin
                    unique case (ffi_reg)
                        4'd0:    rtype_next  = {b, 8'd0};
                        4'd1:    rtype_next  = {rtype_reg[15:8], b};
                        4'd2:    rclass_next = {b, 8'd0};
                        4'd3:    rclass_next = {rclass_reg[15:8], b};
                        4'd8:    rdlen_next  = {b, 8'd0};
                        4'd9:    rdlen_next  = {rdlen_reg[15:8], b};
                        default: ;
                    endcase
                    ffi_next = ffi_inc;
                    if (ffi_inc >= 4'd10)
                    begin
                        priority if (rtype_next == dnsa_pkg::TYPE_A &&
                                     rclass_next == dnsa_pkg::CLASS_IN &&
                                     rdlen_next == dnsa_pkg::A_RDLEN)
                        begin
                            ffi_next   = 4'd0;
                            addr_next  = 32'd0;
                            phase_next = PH_CAPTURE;
                        end
                        else if (rdlen_next == 16'd0)
                        begin
                            cnt_dec     = aleft_reg - 16'd1;
                            aleft_next  = cnt_dec;
                            labels_next = (cnt_dec == 16'd0) ? labels_reg : 8'd0;
                            phase_next  = (cnt_dec == 16'd0) ? PH_NO_A : PH_ANAME;
                        end
                        else
                        begin
                            phase_next = PH_RDATA;
                        end
                    end
                end

                PH_RDATA:
                begin
                    rdlen_next = rdlen_reg - 16'd1;
                    if (rdlen_next == 16'd0)
                    begin
                        cnt_dec     = aleft_reg - 16'd1;
                        aleft_next  = cnt_dec;
                        labels_next = (cnt_dec == 16'd0) ? labels_reg : 8'd0;
                        phase_next  = (cnt_dec == 16'd0) ? PH_NO_A : PH_ANAME;
                    end
                end

                PH_CAPTURE:
                begin
                    addr_next = {addr_reg[23:0], b};
                    ffi_next  = ffi_inc;
                    if (ffi_inc >= 4'd4)
                    begin
                        phase_next = PH_FOUND;
                    end
                end

                PH_FOUND, PH_NO_A, PH_ERROR: ;

                default: ;
            endcase
        end

        // Count bytes, saturating one past the limit
        if (off_reg <= OFF_MAX)
        begin
            off_next = off_reg + OFF_ONE;
        end

        // Form result from the updated state
        priority if (off_next > OFF_MAX)
        begin
            res_word.status = dnsa_pkg::ST_LONG;
        end
        else if (off_next < OFF_HDR)
        begin
            res_word.status = dnsa_pkg::ST_SHORT;
        end
        else if (phase_next == PH_ERROR)
        begin
            res_word.status = sticky_next;
        end
        else if (phase_next == PH_FOUND)
        begin
            res_word.status       = dnsa_pkg::ST_FOUND;
            res_word.ipv4_address = addr_next;
        end
        else if (phase_next == PH_NO_A)
        begin
            res_word.status = dnsa_pkg::ST_NO_A;
        end
        else
        begin
            res_word.status = dnsa_pkg::ST_MALFORMED;
        end

        // Final byte: return to reset values
        if (word.end_of_message)
        begin
            phase_next  = PH_HEADER;
            off_next    = '0;
            flags_next  = 16'd0;
            qleft_next  = 16'd0;
            aleft_next  = 16'd0;
            lbl_next    = 6'd0;
            labels_next = 8'd0;
            ffi_next    = 4'd0;
            rtype_next  = 16'd0;
            rclass_next = 16'd0;
            rdlen_next  = 16'd0;
            addr_next   = 32'd0;
            sticky_next = dnsa_pkg::ST_FOUND;
        end
    end

    assign res_load = step && word.end_of_message;

    // Hold scan state; advance on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            off_reg    <= '0;
            flags_reg  <= 16'd0;
            qleft_reg  <= 16'd0;
            aleft_reg  <= 16'd0;
            lbl_reg    <= 6'd0;
            labels_reg <= 8'd0;
            ffi_reg    <= 4'd0;
            rtype_reg  <= 16'd0;
            rclass_reg <= 16'd0;
            rdlen_reg  <= 16'd0;
            addr_reg   <= 32'd0;
            sticky_reg <= dnsa_pkg::ST_FOUND;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            flags_reg  <= flags_next;
            qleft_reg  <= qleft_next;
            aleft_reg  <= aleft_next;
            lbl_reg    <= lbl_next;
            labels_reg <= labels_next;
            ffi_reg    <= ffi_next;
            rtype_reg  <= rtype_next;
            rclass_reg <= rclass_next;
            rdlen_reg  <= rdlen_next;
            addr_reg   <= addr_next;
            sticky_reg <= sticky_next;
        end
    end

    // A final byte leaves the scanner at the start of a fresh message
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (phase_reg == PH_HEADER && off_reg == '0))
    else $error("scan state not cleared after final byte");

    // The byte counter saturates one past the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        off_reg <= OFF_MAX + OFF_ONE)
    else $error("byte counter ran past saturation");

    // A name never holds more labels than allowed
    assert property (@(posedge clk) disable iff (!rst_n)
        labels_reg <= LABELS_MAX)
    else $error("label count exceeded limit");

    // An address is reported only with a found status
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res_word.status != dnsa_pkg::ST_FOUND |->
            res_word.ipv4_address == 32'd0)
    else $error("address reported without a match");

endmodule

/* src/dnsa_out_reg.sv */
// ----------------------------------------------------------------------------
// dnsa_out_reg
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module dnsa_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  dnsa_pkg::result_word_t load_word,
    output logic                   can_load,
    output logic                   valid,
    input  logic                   stall,
    output dnsa_pkg::result_word_t word
);

    logic                   vld_reg;
    dnsa_pkg::result_word_t word_reg;

    // Register is free when empty or being drained this cycle
    assign can_load = !vld_reg || !stall;

    // Hold the valid flag; drop it when taken, set it on a new result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (can_load)
        begin
            vld_reg <= load;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            word_reg <= load_word;
        end
    end

    assign valid = vld_reg;
    assign word  = word_reg;

endmodule

/* src/dns_response_a_record_parser_top.sv */
// ----------------------------------------------------------------------------
// dns_response_a_record_parser_top
// DNS reply scanner that reports the first IN A address of a message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (byte_valid / byte_stall / byte_word) carries one message
//   byte per word, with end_of_message set on the final byte. Output channel
//   (result_valid / result_stall / result_word) carries one word per message:
//   a status code and the IPv4 address (zero unless the status is found).
//   Throughput: one byte per cycle, sustained, including across message
//   boundaries, unless a final byte waits on a stalled result; the scan
//   state is updated by a single register stage. An accepted byte waits in
//   the input register, and a final byte's result loads the output register.
//   Stalls: a result waiting under result_stall keeps the output register
//   full; the input register still keeps taking bytes, and further bytes
//   are stalled only when the buffered byte is a final byte.
//   Reset: rst_n clears the scanner to the start of a message and empties
//   both the input and the result registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  dnsa_pkg::byte_word_t   byte_word,
    output logic                   result_valid,
    input  logic                   result_stall,
    output dnsa_pkg::result_word_t result_word
);

    logic                   in_vld_reg;
    dnsa_pkg::byte_word_t   in_word_reg;
    logic                   advance;
    logic                   accept;
    logic                   can_load;
    logic                   res_load;
    dnsa_pkg::result_word_t res_word;

    // Scan the buffered byte unless its result has nowhere to go
    assign advance    = in_vld_reg && (!in_word_reg.end_of_message || can_load);
    assign byte_stall = in_vld_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    // Hold the input byte; refill as it is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg <= byte_word;
        end
    end

    dnsa_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .word     (in_word_reg),
        .res_load (res_load),
        .res_word (res_word)
    );

    dnsa_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_word (res_word),
        .can_load  (can_load),
        .valid     (result_valid),
        .stall     (result_stall),
        .word      (result_word)
    );

endmodule
